@@ design/vos_pkg.sv @@
// Package: sizes, payload types and register indexes of the valve open sequencer.
`default_nettype none
package vos_pkg;

  localparam int NUM_CIRCUITS = 8;

  // Circuit index and circuit count widths
  localparam int IDX_W = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;
  localparam int CNT_W = $clog2(NUM_CIRCUITS + 1);

  // Per-circuit masks on the ports are fixed at eight bits
  localparam int MASK_W = 8;
  localparam int USED_W = (NUM_CIRCUITS < MASK_W) ? NUM_CIRCUITS : MASK_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CIRCUITS = 2'd0,
    REG_MAX_OPENING     = 2'd1,
    REG_OPEN_TIME_MS    = 2'd2,
    REG_INVERT_MASK     = 2'd3
  } cfg_reg_e;

  localparam logic [3:0]        ACTIVE_RST    = 4'd8;
  localparam logic [3:0]        MAX_OPEN_RST  = 4'd1;
  localparam logic [31:0]       OPEN_TIME_RST = 32'd30000;
  localparam logic [MASK_W-1:0] INVERT_RST    = '0;

endpackage
`default_nettype wire

@@ design/vos_in_if.sv @@
// Interface: scan tick channel (valid, ready, time, link flag, request mask).
`default_nettype none
interface vos_in_if import vos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [31:0]       now_ms;
  logic              link_up;
  logic [MASK_W-1:0] request_mask;

  modport source (output valid, output now_ms, output link_up, output request_mask,
                  input ready);
  modport sink   (input valid, input now_ms, input link_up, input request_mask,
                  output ready);
endinterface
`default_nettype wire

@@ design/vos_out_if.sv @@
// Interface: result channel (valid, ready, drive/open/moving masks, any-open flag).
`default_nettype none
interface vos_out_if import vos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] drive_mask;
  logic [MASK_W-1:0] open_mask;
  logic [MASK_W-1:0] moving_mask;
  logic              any_open;

  modport source (output valid, output drive_mask, output open_mask, output moving_mask,
                  output any_open, input ready);
  modport sink   (input valid, input drive_mask, input open_mask, input moving_mask,
                  input any_open, output ready);
endinterface
`default_nettype wire

@@ design/valve_open_sequencer.sv @@
// Top level: valve open sequencer, one circuit visited per cycle through a shared timer check.
//
//  channel   dir   handshake          payload
//  in_i      in    valid/ready        now_ms[31:0], link_up, request_mask[7:0]
//  out_o     out   valid/ready        drive_mask[7:0], open_mask[7:0], moving_mask[7:0],
//                                     any_open
//  cfg       in    cfg_we_i           cfg_idx_i[1:0], cfg_data_i[31:0]
//
// A tick runs in steps, n = min(active_circuits, NUM_CIRCUITS): it is taken in, each
// active circuit in turn goes through the shared elapsed-time subtract and compare, and
// the result register is loaded. Ready is high only between ticks; a finished result that
// is not taken holds the sequencer in its last step. Reset clears all circuit flags and
// loads the register defaults.
`default_nettype none
module valve_open_sequencer import vos_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  vos_in_if.sink                     in_i,
  vos_out_if.source                  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_VISIT = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [3:0]        active_q;
  logic [3:0]        max_open_q;
  logic [31:0]       open_time_q;
  logic [MASK_W-1:0] invert_q;

  // Circuit state
  logic [NUM_CIRCUITS-1:0] is_open_q, is_open_d;
  logic [NUM_CIRCUITS-1:0] opening_q, opening_d;
  logic [NUM_CIRCUITS-1:0] drive_q, drive_d;
  logic [31:0]             start_q [NUM_CIRCUITS];

  // Tick context
  logic [31:0]       now_q;
  logic              link_q;
  logic [MASK_W-1:0] req_q;
  logic [CNT_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Result register
  logic              out_valid_q;
  logic [MASK_W-1:0] drive_out_q, open_out_q, moving_out_q;
  logic              any_out_q;

  logic              in_xfer;
  logic              out_free;
  logic [IDX_W-1:0]  k;
  logic [31:0]       elapsed;
  logic              timed_out;
  logic              open_a, opening_a;
  logic [CNT_W-1:0]  cnt_a;
  logic              want, inv;
  logic              start_now;
  logic [NUM_CIRCUITS-1:0] active_vec;
  logic [MASK_W-1:0] drive_m, open_m, moving_m;
  logic              any_m;
  logic [CNT_W-1:0]  pop;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // Clamp the circuit count to the number built
  always_comb begin
    if (32'(in_xfer ? active_q : active_q) > 32'(NUM_CIRCUITS)) begin
      num_d = CNT_W'(NUM_CIRCUITS);
    end else begin
      num_d = CNT_W'(active_q);
    end
  end

  // Circuits in use and opening count at tick start
  always_comb begin
    pop = '0;
    for (int j = 0; j < NUM_CIRCUITS; j++) begin
      active_vec[j] = (32'(j) < 32'(num_q));
    end
    for (int j = 0; j < NUM_CIRCUITS; j++) begin
      if ((32'(j) < 32'(num_d)) && opening_q[j]) begin
        pop = pop + CNT_W'(1);
      end
    end
  end

  // Shared unit: elapsed time with wrap, compared against the open time
  assign k         = idx_q[IDX_W-1:0];
  assign elapsed   = now_q - start_q[k];
  assign timed_out = opening_q[k] && (elapsed > open_time_q);

  assign open_a    = is_open_q[k] || timed_out;
  assign opening_a = opening_q[k] && !timed_out;
  assign cnt_a     = cnt_q - CNT_W'(timed_out);

  assign want = (32'(idx_q) < 32'(MASK_W)) ? req_q[3'(idx_q)] : 1'b0;
  assign inv  = (32'(idx_q) < 32'(MASK_W)) ? invert_q[3'(idx_q)] : 1'b0;

  assign start_now = (state_q == ST_VISIT) && link_q && want && !open_a && !opening_a &&
                     (32'(cnt_a) < 32'(max_open_q));

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    is_open_d = is_open_q;
    opening_d = opening_q;
    drive_d   = drive_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_d = '0;
          cnt_d = pop;
          state_d = (num_d == '0) ? ST_DONE : ST_VISIT;
        end
      end
      ST_VISIT: begin
        is_open_d[k] = open_a;
        opening_d[k] = opening_a;
        cnt_d        = cnt_a;
        if (link_q) begin
          if (!want && (open_a || opening_a)) begin
            // close at once, relay back to idle level
            is_open_d[k] = 1'b0;
            opening_d[k] = 1'b0;
            drive_d[k]   = inv;
            cnt_d        = cnt_a - CNT_W'(opening_a);
          end else if (start_now) begin
            opening_d[k] = 1'b1;
            drive_d[k]   = !inv;
            cnt_d        = cnt_a + CNT_W'(1);
          end
        end
        idx_d = idx_q + CNT_W'(1);
        if (idx_d == num_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result masks from the final circuit state
  always_comb begin
    drive_m  = '0;
    open_m   = '0;
    moving_m = '0;
    any_m    = |(is_open_q & active_vec);
    for (int j = 0; j < USED_W; j++) begin
      drive_m[j]  = drive_q[j] && active_vec[j];
      open_m[j]   = is_open_q[j] && active_vec[j];
      moving_m[j] = opening_q[j] && active_vec[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= ACTIVE_RST;
      max_open_q  <= MAX_OPEN_RST;
      open_time_q <= OPEN_TIME_RST;
      invert_q    <= INVERT_RST;
      is_open_q   <= '0;
      opening_q   <= '0;
      drive_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      num_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_open_q <= is_open_d;
      opening_q <= opening_d;
      drive_q   <= drive_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      if (in_xfer) begin
        num_q <= num_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACTIVE_CIRCUITS: active_q    <= cfg_data_i[3:0];
          REG_MAX_OPENING:     max_open_q  <= cfg_data_i[3:0];
          REG_OPEN_TIME_MS:    open_time_q <= cfg_data_i;
          REG_INVERT_MASK:     invert_q    <= cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q  <= in_i.now_ms;
      link_q <= in_i.link_up;
      req_q  <= in_i.request_mask;
    end
    if (start_now) begin
      start_q[k] <= now_q;
    end
    if ((state_q == ST_DONE) && out_free) begin
      drive_out_q  <= drive_m;
      open_out_q   <= open_m;
      moving_out_q <= moving_m;
      any_out_q    <= any_m;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_mask  = drive_out_q;
  assign out_o.open_mask   = open_out_q;
  assign out_o.moving_mask = moving_out_q;
  assign out_o.any_open    = any_out_q;

endmodule
`default_nettype wire
